### sv/gqr_pkg.sv
// ----------------------------------------------------------------------------
// gqr_pkg
// shared sizes, request and response types, and unit interface structs
// ----------------------------------------------------------------------------
package gqr_pkg;

    localparam int DIM    = 8;
    localparam int DEPTH  = DIM * DIM;
    localparam int IDX_W  = $clog2(DIM);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        ACT_WR_MAT = 2'd0,
        ACT_WR_ACC = 2'd1,
        ACT_RUN    = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
    } req_item_t;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] r_value;
        logic signed [31:0] q_value;
    } rsp_item_t;

    // one rotated entry x*c + y*s
    typedef struct packed {
        logic               valid;
        logic signed [31:0] x;
        logic signed [31:0] c;
        logic signed [31:0] y;
        logic signed [31:0] s;
    } mac_op_t;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] value;
    } mac_res_t;

    // rotation pair, held stable after done
    typedef struct packed {
        logic               done;
        logic signed [31:0] c;
        logic signed [31:0] s;
    } angle_res_t;

endpackage

### sv/gqr_ram.sv
// ----------------------------------------------------------------------------
// gqr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module gqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/gqr_mac.sv
// ----------------------------------------------------------------------------
// gqr_mac
// two-stage rotate unit: x*c + y*s in q2.30, round to nearest, saturate
// ----------------------------------------------------------------------------
module gqr_mac (
    input  logic             clk,
    input  logic             rst_n,
    input  gqr_pkg::mac_op_t op,
    output gqr_pkg::mac_res_t res
);
    import gqr_pkg::*;

    logic               v1_reg;
    logic signed [63:0] p1_reg;
    logic signed [63:0] p2_reg;
    logic signed [63:0] p1_next;
    logic signed [63:0] p2_next;
    logic               v2_reg;
    logic signed [31:0] res_reg;
    logic signed [31:0] res_next;
    logic signed [64:0] sum;
    logic signed [34:0] q;

    assign p1_next = op.x * op.c;
    assign p2_next = op.y * op.s;

    always_comb
    begin
        sum = {p1_reg[63], p1_reg} + {p2_reg[63], p2_reg} + 65'sd536870912;
        q   = sum[64:30];
        if (q > 35'sd2147483647)
        begin
            res_next = 32'sh7fff_ffff;
        end
        else if (q < -35'sd2147483648)
        begin
            res_next = 32'sh8000_0000;
        end
        else
        begin
            res_next = q[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= op.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        res_reg <= res_next;
    end

    assign res.valid = v2_reg;
    assign res.value = res_reg;

endmodule

### sv/gqr_angle.sv
// ----------------------------------------------------------------------------
// gqr_angle
// rotation picker: squares, bit-pair square root, two restoring divisions
// ----------------------------------------------------------------------------
module gqr_angle (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  a,
    input  logic signed [31:0]  b,
    output gqr_pkg::angle_res_t res
);
    import gqr_pkg::*;

    typedef enum logic [5:0] {
        AS_IDLE = 6'b000001,
        AS_SQ   = 6'b000010,
        AS_ROOT = 6'b000100,
        AS_LOAD = 6'b001000,
        AS_DIV  = 6'b010000,
        AS_DONE = 6'b100000
    } ang_state_t;

    ang_state_t         state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               phase_reg, phase_next;
    logic [31:0]        ua_reg, ua_next;
    logic [31:0]        ub_reg, ub_next;
    logic               neg_reg, neg_next;
    logic [63:0]        n_reg, n_next;
    logic [63:0]        root_reg, root_next;
    logic [63:0]        bit_reg, bit_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        dq_reg, dq_next;
    logic signed [31:0] c_reg, c_next;
    logic signed [31:0] s_reg, s_next;
    logic [63:0]        trial;
    logic [63:0]        num;
    logic [32:0]        shifted;
    logic               ge;
    logic [32:0]        diff;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        ua_next    = ua_reg;
        ub_next    = ub_reg;
        neg_next   = neg_reg;
        n_next     = n_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        c_next     = c_reg;
        s_next     = s_reg;
        trial      = root_reg + bit_reg;
        num        = {2'b00, (phase_reg ? ub_reg : ua_reg), 30'd0}
                     + {33'd0, root_reg[31:1]};
        shifted    = {rem_reg, dq_reg[31]};
        ge         = shifted >= {1'b0, root_reg[31:0]};
        diff       = shifted - {1'b0, root_reg[31:0]};

        case (state_reg)
            AS_IDLE:
            begin
                if (start)
                begin
                    ua_next  = a[31] ? 32'(-a) : 32'(a);
                    ub_next  = b[31] ? 32'(-b) : 32'(b);
                    neg_next = a[31] ^ b[31];
                    cnt_next = 5'd0;
                    if ((a == 32'sd0) && (b == 32'sd0))
                    begin
                        // identity rotation
                        c_next     = 32'sh4000_0000;
                        s_next     = 32'sd0;
                        state_next = AS_DONE;
                    end
                    else
                    begin
                        state_next = AS_SQ;
                    end
                end
            end
            AS_SQ:
            begin
                if (cnt_reg == 5'd0)
                begin
                    n_next   = ua_reg * ua_reg;
                    cnt_next = 5'd1;
                end
                else
                begin
                    n_next     = n_reg + (ub_reg * ub_reg);
                    root_next  = 64'd0;
                    bit_next   = 64'd1 << 62;
                    cnt_next   = 5'd0;
                    state_next = AS_ROOT;
                end
            end
            AS_ROOT:
            begin
                if (n_reg >= trial)
                begin
                    n_next    = n_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    phase_next = 1'b0;
                    state_next = AS_LOAD;
                end
            end
            AS_LOAD:
            begin
                rem_next   = num[63:32];
                dq_next    = num[31:0];
                cnt_next   = 5'd0;
                state_next = AS_DIV;
            end
            AS_DIV:
            begin
                rem_next = ge ? diff[31:0] : shifted[31:0];
                dq_next  = {dq_reg[30:0], ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    if (!phase_reg)
                    begin
                        c_next     = {dq_reg[30:0], ge};
                        phase_next = 1'b1;
                        state_next = AS_LOAD;
                    end
                    else
                    begin
                        s_next     = neg_reg ? -$signed({dq_reg[30:0], ge})
                                             : $signed({dq_reg[30:0], ge});
                        state_next = AS_DONE;
                    end
                end
            end
            AS_DONE:
            begin
                state_next = AS_IDLE;
            end
            default:
            begin
                state_next = AS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AS_IDLE;
            cnt_reg   <= 5'd0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
        neg_reg  <= neg_next;
        n_reg    <= n_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        c_reg    <= c_next;
        s_reg    <= s_next;
    end

    assign res.done = (state_reg == AS_DONE);
    assign res.c    = c_reg;
    assign res.s    = s_reg;

endmodule

### sv/givens_qr_tridiagonal_sweep_unit.sv
// ----------------------------------------------------------------------------
// givens_qr_tridiagonal_sweep_unit
// givens qr sweep over a tridiagonal matrix with a rotation accumulator
// ----------------------------------------------------------------------------
//  channel | signals                     | payload
//  --------+-----------------------------+-------------------------------
//  request | req_valid / req_ready       | req_data  (action,row,col,value)
//  result  | rsp_valid / rsp_ready       | rsp_data  (out_row,out_col,r,q)
//
//  a write completes when accepted; a read then waits in the read-wait state for the result register
//  in a sweep, the 32-step square root and the two 32-step divisions of the
//  rotation picker dominate each step
//  only one request is in work at a time; a pending result does not block
//  writes or a sweep, only the next read
//  rst_n clears control state; ram contents are undefined until written
// ----------------------------------------------------------------------------
module givens_qr_tridiagonal_sweep_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  gqr_pkg::req_item_t req_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output gqr_pkg::rsp_item_t rsp_data
);
    import gqr_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_RDWAIT = 7'b0000010,
        ST_LOAD   = 7'b0000100,
        ST_ANGLE  = 7'b0001000,
        ST_MROT   = 7'b0010000,
        ST_QRD    = 7'b0100000,
        ST_QMAC   = 7'b1000000
    } state_t;

    function automatic logic [ADDR_W-1:0] mat_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
        mat_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(DIM) + ADDR_W'(c));
    endfunction

    state_t             state_reg, state_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   ip1, ip2;
    logic               last_i;
    logic               accept;
    logic               in_range;
    logic [ADDR_W-1:0]  req_addr;

    // sweep operands
    logic signed [31:0] a1_reg, a1_next;
    logic signed [31:0] a2_reg, a2_next;
    logic signed [31:0] lb_reg, lb_next;
    logic signed [31:0] uc_reg, uc_next;
    logic signed [31:0] f_reg, f_next;
    logic signed [31:0] q1_reg, q1_next;
    logic signed [31:0] q2_reg, q2_next;

    // read bookkeeping and result register
    logic [2:0]         rd_row_reg, rd_row_next;
    logic [2:0]         rd_col_reg, rd_col_next;
    logic               rd_in_reg, rd_in_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_item_t          rsp_reg, rsp_next;

    // memory ports
    logic               m_we, m_re, q_we, q_re;
    logic [ADDR_W-1:0]  m_waddr, m_raddr, q_waddr, q_raddr;
    logic [DATA_W-1:0]  m_wdata, q_wdata, m_rdata, q_rdata;

    logic               ang_start;
    angle_res_t         ang;
    mac_op_t            mop;
    mac_res_t           mres;
    logic [2:0]         widx;

    assign accept   = req_valid && req_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign in_range = (32'(req_data.row) < DIM) && (32'(req_data.col) < DIM);
    assign req_addr = mat_addr(IDX_W'(req_data.row), IDX_W'(req_data.col));
    assign ip1      = IDX_W'(i_reg + IDX_W'(1));
    assign ip2      = IDX_W'(i_reg + IDX_W'(2));
    assign last_i   = (i_reg == IDX_W'(DIM - 2));
    assign widx     = cnt_reg - 3'd2;

    gqr_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_mat_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (m_re),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    gqr_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_acc_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    gqr_angle u_angle (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ang_start),
        .a     (a1_reg),
        .b     (lb_reg),
        .res   (ang)
    );

    gqr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mop),
        .res   (mres)
    );

    // sequencer: every read is issued after the write it depends on has
    // landed, so the rams never see a read and write of one entry together
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        a1_next        = a1_reg;
        a2_next        = a2_reg;
        lb_next        = lb_reg;
        uc_next        = uc_reg;
        f_next         = f_reg;
        q1_next        = q1_reg;
        q2_next        = q2_reg;
        rd_row_next    = rd_row_reg;
        rd_col_next    = rd_col_reg;
        rd_in_next     = rd_in_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        m_we           = 1'b0;
        m_waddr        = req_addr;
        m_wdata        = req_data.value;
        m_re           = 1'b0;
        m_raddr        = req_addr;
        q_we           = 1'b0;
        q_waddr        = req_addr;
        q_wdata        = req_data.value;
        q_re           = 1'b0;
        q_raddr        = req_addr;
        ang_start      = 1'b0;
        mop.valid      = 1'b0;
        mop.x          = a1_reg;
        mop.c          = ang.c;
        mop.y          = lb_reg;
        mop.s          = ang.s;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_data.action)
                        ACT_WR_MAT:
                        begin
                            m_we = in_range;
                        end
                        ACT_WR_ACC:
                        begin
                            q_we = in_range;
                        end
                        ACT_RUN:
                        begin
                            i_next     = '0;
                            cnt_next   = 3'd0;
                            state_next = ST_LOAD;
                        end
                        ACT_READ:
                        begin
                            m_re        = in_range;
                            q_re        = in_range;
                            rd_row_next = req_data.row;
                            rd_col_next = req_data.col;
                            rd_in_next  = in_range;
                            state_next  = ST_RDWAIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RDWAIT:
            begin
                // ram read data holds until the result register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.out_row = rd_row_reg;
                    rsp_next.out_col = rd_col_reg;
                    rsp_next.r_value = rd_in_reg ? $signed(m_rdata) : 32'sd0;
                    rsp_next.q_value = rd_in_reg ? $signed(q_rdata) : 32'sd0;
                    rsp_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                // pivot, next diagonal, subdiagonal, superdiagonal, fill
                m_re = (cnt_reg < 3'd5);
                case (cnt_reg)
                    3'd0:    m_raddr = mat_addr(i_reg, i_reg);
                    3'd1:    m_raddr = mat_addr(ip1, ip1);
                    3'd2:    m_raddr = mat_addr(ip1, i_reg);
                    3'd3:    m_raddr = mat_addr(i_reg, ip1);
                    3'd4:    m_raddr = last_i ? mat_addr(i_reg, i_reg)
                                              : mat_addr(ip1, ip2);
                    default: m_raddr = mat_addr(i_reg, i_reg);
                endcase
                case (cnt_reg)
                    3'd1:    a1_next = $signed(m_rdata);
                    3'd2:    a2_next = $signed(m_rdata);
                    3'd3:    lb_next = $signed(m_rdata);
                    3'd4:    uc_next = $signed(m_rdata);
                    3'd5:    f_next  = $signed(m_rdata);
                    default: f_next  = f_reg;
                endcase
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    ang_start  = 1'b1;
                    cnt_next   = 3'd0;
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE:
            begin
                if (ang.done)
                begin
                    cnt_next   = 3'd0;
                    state_next = ST_MROT;
                end
            end
            ST_MROT:
            begin
                // six rotated band entries, written back as the rotate unit returns them
                mop.valid = (cnt_reg < 3'd6);
                case (cnt_reg)
                    3'd0:
                    begin
                        mop.x = a1_reg; mop.c = ang.c;  mop.y = lb_reg; mop.s = ang.s;
                    end
                    3'd1:
                    begin
                        mop.x = uc_reg; mop.c = ang.c;  mop.y = a2_reg; mop.s = ang.s;
                    end
                    3'd2:
                    begin
                        mop.x = uc_reg; mop.c = -ang.s; mop.y = a2_reg; mop.s = ang.c;
                    end
                    3'd3:
                    begin
                        mop.x = a1_reg; mop.c = -ang.s; mop.y = lb_reg; mop.s = ang.c;
                    end
                    3'd4:
                    begin
                        mop.x = f_reg;  mop.c = ang.s;  mop.y = 32'sd0; mop.s = 32'sd0;
                    end
                    default:
                    begin
                        mop.x = f_reg;  mop.c = ang.c;  mop.y = 32'sd0; mop.s = 32'sd0;
                    end
                endcase
                m_wdata = mres.value;
                m_we    = mres.valid && !((widx >= 3'd4) && last_i);
                case (widx)
                    3'd0:    m_waddr = mat_addr(i_reg, i_reg);
                    3'd1:    m_waddr = mat_addr(i_reg, ip1);
                    3'd2:    m_waddr = mat_addr(ip1, ip1);
                    3'd3:    m_waddr = mat_addr(ip1, i_reg);
                    3'd4:    m_waddr = mat_addr(i_reg, ip2);
                    default: m_waddr = mat_addr(ip1, ip2);
                endcase
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    k_next     = '0;
                    cnt_next   = 3'd0;
                    state_next = ST_QRD;
                end
            end
            ST_QRD:
            begin
                q_re    = (cnt_reg < 3'd2);
                q_raddr = (cnt_reg == 3'd0) ? mat_addr(k_reg, i_reg)
                                            : mat_addr(k_reg, ip1);
                if (cnt_reg == 3'd1)
                begin
                    q1_next = $signed(q_rdata);
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd2)
                begin
                    q2_next    = $signed(q_rdata);
                    cnt_next   = 3'd0;
                    state_next = ST_QMAC;
                end
            end
            ST_QMAC:
            begin
                mop.valid = (cnt_reg < 3'd2);
                mop.x     = q1_reg;
                mop.y     = q2_reg;
                mop.c     = (cnt_reg == 3'd0) ? ang.c : -ang.s;
                mop.s     = (cnt_reg == 3'd0) ? ang.s : ang.c;
                q_we      = mres.valid;
                q_wdata   = mres.value;
                q_waddr   = (cnt_reg == 3'd2) ? mat_addr(k_reg, i_reg)
                                              : mat_addr(k_reg, ip1);
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    cnt_next = 3'd0;
                    if (k_reg == IDX_W'(DIM - 1))
                    begin
                        if (last_i)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = ip1;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        k_next     = IDX_W'(k_reg + IDX_W'(1));
                        state_next = ST_QRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 3'd0;
            i_reg         <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg     <= a1_next;
        a2_reg     <= a2_next;
        lb_reg     <= lb_next;
        uc_reg     <= uc_next;
        f_reg      <= f_next;
        q1_reg     <= q1_next;
        q2_reg     <= q2_next;
        rd_row_reg <= rd_row_next;
        rd_col_reg <= rd_col_next;
        rd_in_reg  <= rd_in_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

`ifndef SYNTHESIS
    a_mac_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        mres.valid |-> (state_reg == ST_MROT || state_reg == ST_QMAC))
        else $error("rotate result outside a sweep step");

    a_angle_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ang.done |-> (state_reg == ST_ANGLE))
        else $error("rotation finished while not awaited");

    a_mat_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_we && m_re) |-> (m_waddr != m_raddr))
        else $error("matrix ram read and write of one entry together");

    a_acc_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (q_we && q_re) |-> (q_waddr != q_raddr))
        else $error("accumulator ram read and write of one entry together");

    a_rsp_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_RDWAIT))
        else $error("result raised without a read");
`endif

endmodule
